[rtl/sptrk_pkg.sv]
// ----------------------------------------------------------------------------
// sptrk_pkg
// shared types and constants of the shape pair collision tracker
// ----------------------------------------------------------------------------
package sptrk_pkg;

  localparam int unsigned NUM_COLLIDERS_DEF = 64;
  localparam int unsigned ID_W              = 6;
  localparam int unsigned POS_W             = 16;
  localparam int unsigned SIZE_W            = 16;

  localparam logic KIND_RECT   = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_e;

  typedef struct packed {
    logic [ID_W-1:0]   first_id;
    logic [ID_W-1:0]   second_id;
    logic              first_kind;
    logic              second_kind;
    logic [POS_W-1:0]  first_pos_x;
    logic [POS_W-1:0]  first_pos_y;
    logic [SIZE_W-1:0] first_width;
    logic [SIZE_W-1:0] first_height;
    logic [POS_W-1:0]  second_pos_x;
    logic [POS_W-1:0]  second_pos_y;
    logic [SIZE_W-1:0] second_width;
    logic [SIZE_W-1:0] second_height;
  } item_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic diff;
    logic square;
    logic finish;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

[rtl/sptrk_if.sv]
// ----------------------------------------------------------------------------
// sptrk_if
// valid/ready channels for collider pairs and contact results
// ----------------------------------------------------------------------------
interface sptrk_in_if
  import sptrk_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   first_id;
  logic [ID_W-1:0]   second_id;
  logic              first_kind;
  logic              second_kind;
  logic [POS_W-1:0]  first_pos_x;
  logic [POS_W-1:0]  first_pos_y;
  logic [SIZE_W-1:0] first_width;
  logic [SIZE_W-1:0] first_height;
  logic [POS_W-1:0]  second_pos_x;
  logic [POS_W-1:0]  second_pos_y;
  logic [SIZE_W-1:0] second_width;
  logic [SIZE_W-1:0] second_height;

  modport source (
    output valid, first_id, second_id, first_kind, second_kind,
           first_pos_x, first_pos_y, first_width, first_height,
           second_pos_x, second_pos_y, second_width, second_height,
    input  ready
  );

  modport sink (
    input  valid, first_id, second_id, first_kind, second_kind,
           first_pos_x, first_pos_y, first_width, first_height,
           second_pos_x, second_pos_y, second_width, second_height,
    output ready
  );
endinterface

interface sptrk_out_if;
  logic       valid;
  logic       ready;
  logic       overlap;
  logic [1:0] contact_event;

  modport source (output valid, overlap, contact_event, input ready);
  modport sink (input valid, overlap, contact_event, output ready);
endinterface

[rtl/sptrk_hist.sv]
// ----------------------------------------------------------------------------
// sptrk_hist
// per ordered pair touching history, one bit per entry, cleared after reset
// ----------------------------------------------------------------------------
module sptrk_hist
  import sptrk_pkg::*;
#(
  parameter int unsigned NUM_COLLIDERS = NUM_COLLIDERS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic [ID_W-1:0] first_id_i,
  input  logic [ID_W-1:0] second_id_i,
  input  logic            hit_i,
  output logic            was_o,
  output logic            clr_last_o
);

  localparam int unsigned ID_N  = 1 << ID_W;
  localparam int unsigned DEPTH = NUM_COLLIDERS * NUM_COLLIDERS;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [IDX_W-1:0] id_mod [ID_N];
  logic [IDX_W-1:0] idx_d, idx_q;
  logic [IDX_W-1:0] clr_cnt_q;
  logic [IDX_W-1:0] waddr;
  logic             we, wdata;
  logic             mem_q [DEPTH];
  logic             was_q;

  for (genvar g = 0; g < ID_N; g++) begin : g_mod
    assign id_mod[g] = IDX_W'(g % NUM_COLLIDERS);
  end

  assign idx_d = id_mod[first_id_i] * IDX_W'(NUM_COLLIDERS) + id_mod[second_id_i];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_last_o ? '0 : clr_cnt_q + 1'b1;
    end
  end

  assign clr_last_o = (clr_cnt_q == IDX_W'(DEPTH - 1));
  assign we         = cmd_i.clear | cmd_i.finish;
  assign waddr      = cmd_i.clear ? clr_cnt_q : idx_q;
  assign wdata      = cmd_i.clear ? 1'b0 : hit_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.diff) begin
      was_q <= mem_q[idx_q];
    end
  end

  assign was_o = was_q;

endmodule

[rtl/sptrk_dp.sv]
// ----------------------------------------------------------------------------
// sptrk_dp
// overlap datapath: edge setup, clamp and difference, squares, compare
// ----------------------------------------------------------------------------
module sptrk_dp
  import sptrk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  item_t      item_i,
  input  logic       was_i,
  input  logic       out_ready_i,
  output logic       hit_o,
  output logic       out_free_o,
  output logic       out_valid_o,
  output logic       overlap_o,
  output logic [1:0] event_o
);

  item_t              item_q;
  logic signed [17:0] p1x, p1y, p2x, p2y, w1, h1, w2, h2;
  logic signed [17:0] cx, cy, cw, rx, ry, rw, rh;
  logic signed [17:0] ddx, ddy, adx, ady;
  logic               both_rect, both_circle;
  logic               rr_hit_d;

  logic               rr_q, cc_q, rr_hit_q;
  logic signed [17:0] u_x_q, u_y_q, lo_x_q, lo_y_q, hi_x_q, hi_y_q;
  logic [16:0]        rad_q;

  logic signed [18:0] ux, uy, lx, ly, hx, hy;
  logic signed [18:0] dx_d, dy_d, dx_q, dy_q;

  logic signed [37:0] sqx_d, sqy_d;
  logic [37:0]        sqx_q, sqy_q;
  logic [33:0]        r2_q;
  logic [38:0]        dist2;

  logic               out_valid_q, overlap_q;
  contact_e           ev_d, ev_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // positions doubled so every half size is exact
  assign p1x = {item_q.first_pos_x[15], item_q.first_pos_x, 1'b0};
  assign p1y = {item_q.first_pos_y[15], item_q.first_pos_y, 1'b0};
  assign p2x = {item_q.second_pos_x[15], item_q.second_pos_x, 1'b0};
  assign p2y = {item_q.second_pos_y[15], item_q.second_pos_y, 1'b0};
  assign w1  = {2'b00, item_q.first_width};
  assign h1  = {2'b00, item_q.first_height};
  assign w2  = {2'b00, item_q.second_width};
  assign h2  = {2'b00, item_q.second_height};

  assign both_rect   = (item_q.first_kind == KIND_RECT) && (item_q.second_kind == KIND_RECT);
  assign both_circle = (item_q.first_kind == KIND_CIRCLE) &&
                       (item_q.second_kind == KIND_CIRCLE);

  // circle against rectangle: pick which side is the circle
  always_comb begin
    if (item_q.first_kind == KIND_CIRCLE) begin
      cx = p1x; cy = p1y; cw = w1;
      rx = p2x; ry = p2y; rw = w2; rh = h2;
    end else begin
      cx = p2x; cy = p2y; cw = w2;
      rx = p1x; ry = p1y; rw = w1; rh = h1;
    end
  end

  assign ddx = p1x - p2x;
  assign ddy = p1y - p2y;
  assign adx = ddx[17] ? -ddx : ddx;
  assign ady = ddy[17] ? -ddy : ddy;
  assign rr_hit_d = (unsigned'(adx) < unsigned'(w1 + w2)) &&
                    (unsigned'(ady) < unsigned'(h1 + h2));

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      rr_q     <= both_rect;
      cc_q     <= both_circle;
      rr_hit_q <= rr_hit_d;
      if (both_circle) begin
        u_x_q  <= p1x - w1;
        u_y_q  <= p1y - h1;
        lo_x_q <= p2x - w2;
        lo_y_q <= p2y - h2;
        hi_x_q <= p2x - w2;
        hi_y_q <= p2y - h2;
        rad_q  <= 17'(w1 + w2);
      end else begin
        u_x_q  <= cx;
        u_y_q  <= cy;
        lo_x_q <= rx - rw;
        lo_y_q <= ry - rh;
        hi_x_q <= rx + rw;
        hi_y_q <= ry + rh;
        rad_q  <= 17'(cw);
      end
    end
  end

  assign ux = {u_x_q[17], u_x_q};
  assign uy = {u_y_q[17], u_y_q};
  assign lx = {lo_x_q[17], lo_x_q};
  assign ly = {lo_y_q[17], lo_y_q};
  assign hx = {hi_x_q[17], hi_x_q};
  assign hy = {hi_y_q[17], hi_y_q};

  // distance to the clamped point, or between shifted circle points
  always_comb begin
    if (cc_q) begin
      dx_d = ux - lx;
      dy_d = uy - ly;
    end else begin
      dx_d = (ux > hx) ? ux - hx : ((ux < lx) ? ux - lx : '0);
      dy_d = (uy > hy) ? uy - hy : ((uy < ly) ? uy - ly : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign sqx_d = dx_q * dx_q;
  assign sqy_d = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sqx_q <= unsigned'(sqx_d);
      sqy_q <= unsigned'(sqy_d);
      r2_q  <= rad_q * rad_q;
    end
  end

  assign dist2 = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign hit_o = rr_q ? rr_hit_q : (dist2 <= {5'b0, r2_q});

  always_comb begin
    if (was_i) begin
      ev_d = hit_o ? EV_STAY : EV_EXIT;
    end else begin
      ev_d = hit_o ? EV_ENTER : EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      overlap_q <= hit_o;
      ev_q      <= ev_d;
    end
  end

  assign out_free_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign overlap_o   = overlap_q;
  assign event_o     = ev_q;

`ifndef SYNTHESIS
  a_event_matches_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (overlap_q == ((ev_q == EV_ENTER) || (ev_q == EV_STAY))))
    else $error("contact event disagrees with overlap");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result appeared without a finish step");

  a_finish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finish step did not present a result");
`endif

endmodule

[rtl/sptrk_ctrl.sv]
// ----------------------------------------------------------------------------
// sptrk_ctrl
// sequencer: history clear after reset, then accept and step one pair
// ----------------------------------------------------------------------------
module sptrk_ctrl
  import sptrk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_DIFF,
    S_SQUARE,
    S_FINISH
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = (state_q == S_CLEAR);
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prep   = (state_q == S_PREP);
    cmd_o.diff   = (state_q == S_DIFF);
    cmd_o.square = (state_q == S_SQUARE);
    cmd_o.finish = (state_q == S_FINISH) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      unique case (state_q)
        S_CLEAR:  if (sts_i.clr_last) state_q <= S_IDLE;
        S_IDLE:   if (in_valid_i) state_q <= S_PREP;
        S_PREP:   state_q <= S_DIFF;
        S_DIFF:   state_q <= S_SQUARE;
        S_SQUARE: state_q <= S_FINISH;
        S_FINISH: if (sts_i.out_free) state_q <= S_IDLE;
        default:  state_q <= S_CLEAR;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free)
    else $error("result written over an untaken result");

  a_load_starts_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_PREP))
    else $error("accepted pair did not enter setup");
`endif

endmodule

[rtl/shape_pair_collision_tracker_unit.sv]
// ----------------------------------------------------------------------------
// shape_pair_collision_tracker_unit
// rectangle/circle pair overlap test with enter, stay and exit tracking
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_i    | in  | pair ids, kinds, positions and sizes
//  out_o   | out | overlap flag and contact event
//
//  each pair goes through accept, edge setup, clamp/difference, squares,
//  compare and history write; the controller walks each pair through all
//  five steps before it takes the next one
//  after reset a clearing pass over NUM_COLLIDERS squared entries (4096 by
//  default) zeroes the history; in_i.ready stays low during it
//  a result waits in the output register; the next pair is accepted while
//  it waits, and a stalled output holds the following pair at its last step
// ----------------------------------------------------------------------------
module shape_pair_collision_tracker_unit
  import sptrk_pkg::*;
#(
  parameter int unsigned NUM_COLLIDERS = NUM_COLLIDERS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sptrk_in_if.sink     in_i,
  sptrk_out_if.source  out_o
);

  item_t item;
  cmd_t  cmd;
  sts_t  sts;
  logic  hit, was, out_free, clr_last;

  assign item = '{
    first_id:      in_i.first_id,
    second_id:     in_i.second_id,
    first_kind:    in_i.first_kind,
    second_kind:   in_i.second_kind,
    first_pos_x:   in_i.first_pos_x,
    first_pos_y:   in_i.first_pos_y,
    first_width:   in_i.first_width,
    first_height:  in_i.first_height,
    second_pos_x:  in_i.second_pos_x,
    second_pos_y:  in_i.second_pos_y,
    second_width:  in_i.second_width,
    second_height: in_i.second_height
  };

  assign sts.out_free = out_free;
  assign sts.clr_last = clr_last;

  sptrk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  sptrk_hist #(
    .NUM_COLLIDERS (NUM_COLLIDERS)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .first_id_i  (in_i.first_id),
    .second_id_i (in_i.second_id),
    .hit_i       (hit),
    .was_o       (was),
    .clr_last_o  (clr_last)
  );

  sptrk_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item),
    .was_i       (was),
    .out_ready_i (out_o.ready),
    .hit_o       (hit),
    .out_free_o  (out_free),
    .out_valid_o (out_o.valid),
    .overlap_o   (out_o.overlap),
    .event_o     (out_o.contact_event)
  );

endmodule
